[hdl/itpd_pkg.sv]
`timescale 1ns / 1ps

package itpd_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN_LOAD,
      ST_ALIGN,
      ST_DIR,
      ST_CHECK,
      ST_READ,
      ST_CMP
   } state_type;

   // register indexes on the csr port
   localparam int          CSR_INDEX_W      = 2;
   localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0]  REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0]  REG_PIXEL_MODE   = 2'd2;

   localparam logic [1:0]  MODE_ONE_BIT     = 2'd1;

   // stored pixel codes
   localparam logic [1:0]  CODE_WHITE       = 2'd0;
   localparam logic [1:0]  CODE_CLEAR       = 2'd2;

   localparam int          PX_W             = 2;
   localparam int          PX_PER_WORD      = 8;
   localparam int          WORD_W           = PX_W * PX_PER_WORD;

   localparam int          COUNT_W          = 17;
   localparam logic [16:0] COUNT_MAX        = 17'h1FFFF;
   localparam logic [4:0]  DIV_LAST_STEP    = 5'd16;

endpackage

[hdl/itpd_ram.sv]
`timescale 1ns / 1ps

module itpd_ram #(
   parameter  int DATA_W = 16,
   parameter  int DEPTH  = 8192,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [DATA_W-1:0] wr_mask,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [DATA_W-1:0] rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < DATA_W; i++) begin
            if (wr_mask[i]) begin
               mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[hdl/image_tile_period_detect.sv]
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// request   req_data_byte, req_last                 taken when start & !busy
// response  rsp_horizontal_period,                  rsp_valid high for one cycle
//           rsp_vertical_period, rsp_short_load
// csr       csr_we, csr_index, csr_wdata            written when csr_we is high
//
// Bytes load one per cycle while idle; the store takes a whole byte in one masked write.
// After the last byte the search runs on the two-port pixel memory: a pixel compare steps
// through check, read and compare; a row step uses check, and each direction opens in dir.
// A csr write while idle sets busy: the byte position is re-derived by a bit-serial divide.
// Synchronous reset clears control state; the pixel memory is not cleared.
// The receiver cannot stall; a response is shown for exactly one cycle.
`timescale 1ns / 1ps

module image_tile_period_detect #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_last,
   output logic                             rsp_valid,
   output logic [6:0]                       rsp_horizontal_period,
   output logic [6:0]                       rsp_vertical_period,
   output logic                             rsp_short_load,
   input  logic                             csr_we,
   input  logic [itpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   localparam int WPR   = (MAX_WIDTH + 7) / 8;
   localparam int DEPTH = WPR * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = itpd_pkg::WORD_W;

   itpd_pkg::state_type state_ff, state_in;

   logic [7:0]  width_ff, height_ff;
   logic [1:0]  mode_ff;
   logic [16:0] count_ff, count_in;
   logic [5:0]  cb_ff, cb_in;
   logic [7:0]  row_ff, row_in;
   logic [16:0] div_q_ff, div_q_in;
   logic [6:0]  div_r_ff, div_r_in;
   logic [4:0]  div_n_ff, div_n_in;
   logic        dir_ff, dir_in;
   logic [6:0]  p_ff, p_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [6:0]  hper_ff, hper_in;
   logic        short_ff, short_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_h_ff, rsp_h_in;
   logic [6:0]  rsp_v_ff, rsp_v_in;
   logic        rsp_short_ff, rsp_short_in;
   logic [2:0]  sel_a_ff, sel_b_ff;
   logic        oob_a_ff, oob_b_ff;

   logic        two_bit;
   logic [8:0]  width_sum;
   logic [5:0]  groups;
   logic [6:0]  stride;
   logic [14:0] total;
   logic        accept;
   logic [16:0] count_inc;

   logic [7:0]  div_r2;
   logic        div_ge;
   logic [6:0]  div_r_new;
   logic [16:0] div_q_new;

   logic [4:0]    widx;
   logic          place_ok;
   logic [WW-1:0] wr_data, wr_mask;
   logic [AW-1:0] wr_addr;
   logic [6:0]    cb_inc;

   logic [8:0]    xb, yb;
   logic [6:0]    lim;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [WW-1:0] rd_data_a, rd_data_b;
   logic [1:0]    pix_a, pix_b;
   logic          dir_done;
   logic [6:0]    dir_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd1;
         height_ff <= 8'd1;
         mode_ff   <= itpd_pkg::MODE_ONE_BIT;
      end else if (csr_we) begin
         unique case (csr_index)
            itpd_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            itpd_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            itpd_pkg::REG_PIXEL_MODE:   mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign two_bit   = (mode_ff != itpd_pkg::MODE_ONE_BIT);
   assign width_sum = {1'b0, width_ff} + 9'd7;
   assign groups    = width_sum[8:3];
   assign stride    = two_bit ? {groups, 1'b0} : {1'b0, groups};
   assign total     = 15'(stride) * 15'(height_ff);
   assign accept    = start && (state_ff == itpd_pkg::ST_IDLE);
   assign count_inc = (count_ff == itpd_pkg::COUNT_MAX) ? count_ff : count_ff + 17'd1;

   // restoring divide step: count / stride gives row and byte-in-row
   assign div_r2    = {div_r_ff, div_q_ff[16]};
   assign div_ge    = (div_r2 >= {1'b0, stride});
   assign div_r_new = div_ge ? 7'(div_r2 - {1'b0, stride}) : div_r2[6:0];
   assign div_q_new = {div_q_ff[15:0], div_ge};

   // byte placement into one 8-pixel word
   assign widx     = two_bit ? cb_ff[5:1] : cb_ff[4:0];
   assign place_ok = (count_ff < 17'(total)) && ({1'b0, row_ff} < 9'(MAX_HEIGHT));
   assign wr_addr  = AW'(row_ff) * AW'(WPR) + AW'(widx);
   assign cb_inc   = {1'b0, cb_ff} + 7'd1;

   always_comb begin
      logic [7:0] px_x;
      logic       in_group;
      logic [1:0] pair;
      for (int i = 0; i < itpd_pkg::PX_PER_WORD; i++) begin
         px_x     = {widx, 3'(i)};
         in_group = !two_bit || ((i >= 4) == cb_ff[0]);
         pair     = req_data_byte[6 - 2 * (i % 4) +: 2];
         if (two_bit) begin
            wr_data[2*i +: 2] = pair[1] ? itpd_pkg::CODE_CLEAR : {1'b0, pair[0]};
         end else begin
            wr_data[2*i +: 2] = {1'b0, req_data_byte[7 - i]};
         end
         wr_mask[2*i +: 2] = {2{place_ok && in_group && (px_x < width_ff)
                                && ({1'b0, px_x} < 9'(MAX_WIDTH))}};
      end
   end

   // search addressing; partner pixel is p steps along the current direction
   assign xb        = {1'b0, x_ff} + (dir_ff ? 9'd0 : {2'b0, p_ff});
   assign yb        = {1'b0, y_ff} + (dir_ff ? {2'b0, p_ff} : 9'd0);
   assign lim       = dir_ff ? height_ff[7:1] : width_ff[7:1];
   assign rd_addr_a = AW'(y_ff) * AW'(WPR) + AW'(x_ff[7:3]);
   assign rd_addr_b = AW'(yb[7:0]) * AW'(WPR) + AW'(xb[7:3]);

   itpd_ram #(
      .DATA_W (WW),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .wr_mask   (wr_mask),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // lane select and out-of-store flags track the registered read
   always_ff @(posedge clock) begin
      sel_a_ff <= x_ff[2:0];
      sel_b_ff <= xb[2:0];
      oob_a_ff <= ({1'b0, x_ff} >= 9'(MAX_WIDTH)) || ({1'b0, y_ff} >= 9'(MAX_HEIGHT));
      oob_b_ff <= (xb >= 9'(MAX_WIDTH)) || (yb >= 9'(MAX_HEIGHT));
   end

   assign pix_a = oob_a_ff ? itpd_pkg::CODE_WHITE : rd_data_a[{sel_a_ff, 1'b0} +: 2];
   assign pix_b = oob_b_ff ? itpd_pkg::CODE_WHITE : rd_data_b[{sel_b_ff, 1'b0} +: 2];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itpd_pkg::ST_IDLE;
         count_ff     <= '0;
         cb_ff        <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cb_ff        <= cb_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      div_n_ff     <= div_n_in;
      dir_ff       <= dir_in;
      p_ff         <= p_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      hper_ff      <= hper_in;
      short_ff     <= short_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_v_ff     <= rsp_v_in;
      rsp_short_ff <= rsp_short_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cb_in        = cb_ff;
      row_in       = row_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_n_in     = div_n_ff;
      dir_in       = dir_ff;
      p_in         = p_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      hper_in      = hper_ff;
      short_in     = short_ff;
      rsp_valid_in = 1'b0;
      rsp_h_in     = rsp_h_ff;
      rsp_v_in     = rsp_v_ff;
      rsp_short_in = rsp_short_ff;
      dir_done     = 1'b0;
      dir_val      = '0;

      unique case (state_ff)
         itpd_pkg::ST_IDLE: begin
            if (accept) begin
               count_in = count_inc;
               if (cb_inc == stride) begin
                  cb_in  = '0;
                  row_in = row_ff + 8'd1;
               end else begin
                  cb_in = cb_inc[5:0];
               end
               if (req_last) begin
                  short_in = (count_inc < 17'(total));
                  count_in = '0;
                  cb_in    = '0;
                  row_in   = '0;
                  dir_in   = 1'b0;
                  state_in = itpd_pkg::ST_DIR;
               end else if (csr_we) begin
                  state_in = itpd_pkg::ST_ALIGN_LOAD;
               end
            end else if (csr_we) begin
               state_in = itpd_pkg::ST_ALIGN_LOAD;
            end
         end
         itpd_pkg::ST_ALIGN_LOAD: begin
            div_q_in = count_ff;
            div_r_in = '0;
            div_n_in = '0;
            state_in = itpd_pkg::ST_ALIGN;
         end
         itpd_pkg::ST_ALIGN: begin
            div_q_in = div_q_new;
            div_r_in = div_r_new;
            div_n_in = div_n_ff + 5'd1;
            if (div_n_ff == itpd_pkg::DIV_LAST_STEP) begin
               row_in   = div_q_new[7:0];
               cb_in    = div_r_new[5:0];
               state_in = itpd_pkg::ST_IDLE;
            end
         end
         itpd_pkg::ST_DIR: begin
            x_in = '0;
            y_in = '0;
            p_in = 7'd1;
            if (lim == 7'd0) begin
               dir_done = 1'b1;
            end else begin
               state_in = itpd_pkg::ST_CHECK;
            end
         end
         itpd_pkg::ST_CHECK: begin
            if (yb >= {1'b0, height_ff}) begin
               dir_done = 1'b1;
               dir_val  = p_ff;
            end else if (xb >= {1'b0, width_ff}) begin
               x_in = '0;
               y_in = y_ff + 8'd1;
            end else begin
               state_in = itpd_pkg::ST_READ;
            end
         end
         itpd_pkg::ST_READ: begin
            state_in = itpd_pkg::ST_CMP;
         end
         itpd_pkg::ST_CMP: begin
            if (pix_a != pix_b) begin
               if (p_ff == lim) begin
                  dir_done = 1'b1;
               end else begin
                  p_in     = p_ff + 7'd1;
                  x_in     = '0;
                  y_in     = '0;
                  state_in = itpd_pkg::ST_CHECK;
               end
            end else begin
               x_in     = x_ff + 8'd1;
               state_in = itpd_pkg::ST_CHECK;
            end
         end
         default: state_in = itpd_pkg::ST_IDLE;
      endcase

      // horizontal result is held; vertical result closes the transaction
      if (dir_done) begin
         if (!dir_ff) begin
            hper_in  = dir_val;
            dir_in   = 1'b1;
            state_in = itpd_pkg::ST_DIR;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_h_in     = hper_ff;
            rsp_v_in     = dir_val;
            rsp_short_in = short_ff;
            state_in     = itpd_pkg::ST_IDLE;
         end
      end

      // a csr write re-derives the load position from the byte count
      if (csr_we && ((state_ff == itpd_pkg::ST_ALIGN_LOAD)
                     || (state_ff == itpd_pkg::ST_ALIGN))) begin
         state_in = itpd_pkg::ST_ALIGN_LOAD;
      end
   end

   assign busy                  = (state_ff != itpd_pkg::ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_horizontal_period = rsp_h_ff;
   assign rsp_vertical_period   = rsp_v_ff;
   assign rsp_short_load        = rsp_short_ff;

endmodule
